### rtl/midi_message_decoder_defines.svh
// ----------------------------------------------------------------------------
// MIDI message decoder assertion macros
// Shared property macros for the checks at the end of the top level. All of
// them sample on the rising edge of clock and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_DECODER_DEFINES_SVH
`define MIDI_MESSAGE_DECODER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MMD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("midi_message_decoder check failed");

// The consequent holds in the cycle after the antecedent.
`define MMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("midi_message_decoder check failed");

`endif

### rtl/mmd_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message decoder package
// Status and controller codes, modes, shared structs and the mode heuristic.
// ----------------------------------------------------------------------------
`default_nettype none

package mmd_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_MODE_OVERRIDE = '0;

   typedef enum logic [2:0] {
      EV_NOTE_ON   = 3'd0,
      EV_NOTE_OFF  = 3'd1,
      EV_BEND      = 3'd2,
      EV_PRESSURE  = 3'd3,
      EV_CONTROL   = 3'd4
   } event_kind_type;

   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_CONTROL  = 4'hB;
   localparam logic [3:0] ST_PRESSURE = 4'hD;
   localparam logic [3:0] ST_BEND     = 4'hE;
   localparam logic [3:0] ST_SYSTEM   = 4'hF;

   localparam logic [1:0] MODE_AUTO    = 2'd0;
   localparam logic [1:0] MODE_MPE     = 2'd1;
   localparam logic [1:0] MODE_CLASSIC = 2'd2;
   localparam logic [1:0] MODE_WIND    = 2'd3;

   localparam logic [6:0] CC_BREATH     = 7'd2;
   localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
   localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
   localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
   localparam logic [6:0] CC_RPN_LSB    = 7'd100;
   localparam logic [6:0] CC_RPN_MSB    = 7'd101;

   localparam logic [6:0] RPN_NULL        = 7'd127;
   localparam logic [6:0] RPN_MSB_GROUP   = 7'd0;
   localparam logic [6:0] RPN_BEND_RANGE  = 7'd0;
   localparam logic [6:0] RPN_MPE_CONFIG  = 7'd6;

   localparam logic [6:0] RANGE_DEFAULT = 7'd2;
   localparam logic [6:0] RANGE_MPE     = 7'd48;
   localparam logic [3:0] ZONE_MAX      = 4'd15;
   localparam logic [4:0] BREATH_LIMIT  = 5'd16;

   typedef struct packed {
      logic       ok;
      logic [3:0] code;
      logic [3:0] ch;
      logic [6:0] v1;
      logic [6:0] v2;
   } msg_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] members;
   } zone_wr_type;

   function automatic logic two_or_more(input logic [15:0] v);
      return |(v & (v - 16'd1));
   endfunction

   function automatic logic [1:0] choose_mode(input logic zone_rx,
                                              input logic [15:0] notes,
                                              input logic [15:0] exprs,
                                              input logic [4:0] breath);
      logic [15:0] mn;
      logic [15:0] me;
      mn = notes & 16'hFFFE;
      me = exprs & 16'hFFFE;
      if (zone_rx) begin
         return MODE_MPE;
      end else if (two_or_more(mn) && two_or_more(mn & me)) begin
         return MODE_MPE;
      end else if (!two_or_more(notes) && breath >= BREATH_LIMIT) begin
         return MODE_WIND;
      end
      return MODE_CLASSIC;
   endfunction

endpackage

`default_nettype wire

### rtl/mmd_parse.sv
// ----------------------------------------------------------------------------
// MIDI message parser
// Resolves running status, drops system messages and masks data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_parse (
   input  wire logic [7:0]      status_byte,
   input  wire logic [7:0]      first_data,
   input  wire logic [7:0]      second_data,
   input  wire logic [7:0]      prev_status,
   output mmd_pkg::msg_type     msg
);
   import mmd_pkg::*;

   logic [7:0] st;
   logic [7:0] d1;
   logic [7:0] d2;
   logic       run_ok;

   always_comb begin
      run_ok = 1'b1;
      st     = status_byte;
      d1     = first_data;
      d2     = second_data;
      if (!status_byte[7]) begin
         run_ok = prev_status[7];
         st     = prev_status;
         d1     = status_byte;
         d2     = first_data;
      end
      msg.ok   = run_ok && (st[7:4] != ST_SYSTEM);
      msg.code = st[7:4];
      msg.ch   = st[3:0];
      msg.v1   = d1[6:0];
      msg.v2   = d2[6:0];
   end

endmodule

`default_nettype wire

### rtl/mmd_chan_regs.sv
// ----------------------------------------------------------------------------
// MIDI per-channel parameter registers
// Holds the RPN and NRPN selection and the bend range for each channel, and
// raises a zone update on an MPE configuration message.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_chan_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire mmd_pkg::msg_type msg,
   input  wire logic [1:0]       cur_mode,
   input  wire logic [3:0]       cur_members,
   output logic [6:0]            bend_range,
   output mmd_pkg::zone_wr_type  zone_wr
);
   import mmd_pkg::*;

   logic [6:0] range_ff [16];
   logic [6:0] range_in [16];
   logic       range_set_ff [16];
   logic       range_set_in [16];
   logic [6:0] msb_ff [16];
   logic [6:0] msb_in [16];
   logic [6:0] lsb_ff [16];
   logic [6:0] lsb_in [16];
   logic       nrpn_ff [16];
   logic       nrpn_in [16];
   logic       is_cc;
   logic       member;

   assign is_cc = fire && msg.ok && (msg.code == ST_CONTROL);

   always_comb begin
      range_in     = range_ff;
      range_set_in = range_set_ff;
      msb_in       = msb_ff;
      lsb_in       = lsb_ff;
      nrpn_in      = nrpn_ff;
      zone_wr      = '0;
      if (is_cc) begin
         unique case (msg.v1)
            CC_RPN_MSB: begin
               msb_in[msg.ch]  = msg.v2;
               nrpn_in[msg.ch] = 1'b0;
            end
            CC_RPN_LSB: begin
               lsb_in[msg.ch]  = msg.v2;
               nrpn_in[msg.ch] = 1'b0;
            end
            CC_NRPN_MSB, CC_NRPN_LSB: begin
               nrpn_in[msg.ch] = 1'b1;
            end
            CC_DATA_ENTRY: begin
               if (!nrpn_ff[msg.ch] && msb_ff[msg.ch] == RPN_MSB_GROUP) begin
                  if (lsb_ff[msg.ch] == RPN_BEND_RANGE) begin
                     range_in[msg.ch]     = msg.v2;
                     range_set_in[msg.ch] = 1'b1;
                  end else if (lsb_ff[msg.ch] == RPN_MPE_CONFIG && msg.ch == 4'd0) begin
                     zone_wr.valid   = 1'b1;
                     zone_wr.members = (msg.v2 > {3'd0, ZONE_MAX}) ? ZONE_MAX : msg.v2[3:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            range_ff[i]     <= RANGE_DEFAULT;
            range_set_ff[i] <= 1'b0;
            msb_ff[i]       <= RPN_NULL;
            lsb_ff[i]       <= RPN_NULL;
            nrpn_ff[i]      <= 1'b0;
         end
      end else begin
         range_ff     <= range_in;
         range_set_ff <= range_set_in;
         msb_ff       <= msb_in;
         lsb_ff       <= lsb_in;
         nrpn_ff      <= nrpn_in;
      end
   end

   assign member = (cur_members != 4'd0) && (msg.ch != 4'd0) && (msg.ch <= cur_members);

   always_comb begin
      if (range_set_ff[msg.ch]) begin
         bend_range = range_ff[msg.ch];
      end else if (cur_mode == MODE_MPE && member) begin
         bend_range = RANGE_MPE;
      end else begin
         bend_range = RANGE_DEFAULT;
      end
   end

endmodule

`default_nettype wire

### rtl/mmd_mode_track.sv
// ----------------------------------------------------------------------------
// MIDI input mode tracker
// Keeps the note and expression channel masks, the breath count and the MPE
// zone, and works out the input mode after the messages that change it.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_mode_track (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire mmd_pkg::msg_type     msg,
   input  wire mmd_pkg::zone_wr_type zone_wr,
   input  wire logic [1:0]           mode_force,
   output logic [1:0]                cur_mode,
   output logic [3:0]                cur_members,
   output logic [1:0]                next_mode,
   output logic [3:0]                next_members
);
   import mmd_pkg::*;

   logic [15:0] notes_ff;
   logic [15:0] notes_in;
   logic [15:0] exprs_ff;
   logic [15:0] exprs_in;
   logic [4:0]  breath_ff;
   logic [4:0]  breath_in;
   logic        zone_rx_ff;
   logic        zone_rx_in;
   logic [3:0]  members_ff;
   logic [3:0]  members_in;
   logic [1:0]  detected_ff;
   logic [1:0]  detected_in;
   logic [15:0] ch_bit;
   logic        act;
   logic        note_on;
   logic        breath;
   logic        expr;

   assign act     = fire && msg.ok;
   assign ch_bit  = 16'd1 << msg.ch;
   assign note_on = act && (msg.code == ST_NOTE_ON) && (msg.v2 != 7'd0);
   assign breath  = act && (msg.code == ST_CONTROL) && (msg.v1 == CC_BREATH);
   assign expr    = act && (msg.code == ST_BEND || msg.code == ST_PRESSURE);

   always_comb begin
      notes_in   = note_on ? (notes_ff | ch_bit) : notes_ff;
      exprs_in   = expr ? (exprs_ff | ch_bit) : exprs_ff;
      breath_in  = (breath && breath_ff < BREATH_LIMIT) ? breath_ff + 5'd1 : breath_ff;
      zone_rx_in = zone_wr.valid ? (zone_wr.members != 4'd0) : zone_rx_ff;
      members_in = zone_wr.valid ? zone_wr.members : members_ff;
      if (note_on || breath || zone_wr.valid) begin
         detected_in = choose_mode(zone_rx_in, notes_in, exprs_in, breath_in);
      end else begin
         detected_in = detected_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         notes_ff    <= '0;
         exprs_ff    <= '0;
         breath_ff   <= '0;
         zone_rx_ff  <= 1'b0;
         members_ff  <= ZONE_MAX;
         detected_ff <= MODE_CLASSIC;
      end else begin
         notes_ff    <= notes_in;
         exprs_ff    <= exprs_in;
         breath_ff   <= breath_in;
         zone_rx_ff  <= zone_rx_in;
         members_ff  <= members_in;
         detected_ff <= detected_in;
      end
   end

   assign cur_mode     = (mode_force != MODE_AUTO) ? mode_force : detected_ff;
   assign cur_members  = members_ff;
   assign next_mode    = (mode_force != MODE_AUTO) ? mode_force : detected_in;
   assign next_members = members_in;

endmodule

`default_nettype wire

### rtl/midi_message_decoder.sv
// ----------------------------------------------------------------------------
// MIDI channel message decoder
// Decodes one three-byte MIDI message per beat into one event beat, with
// running status, RPN bend range, MPE zone setup and input mode detection.
// ----------------------------------------------------------------------------
// Usage: the request channel carries one message per beat (status byte and
// two data bytes; under running status the first two bytes are data). The
// response channel returns exactly one beat per request beat, in order; a
// beat with rsp_event_valid low reports a dropped or ignored message but
// still carries the current mode and zone size.
// A request beat is held in an input register and decoded from there into
// the output register once that register is free, so rsp_valid rises after
// the beat has passed both registers. One message is taken every cycle while
// the receiver keeps rsp_ready high; the decode path is a short compare tree
// and one 14 by 8 bit multiply for the bend value.
// When the receiver holds rsp_ready low the output register keeps its beat
// and the input register can still take one more beat before req_ready drops.
// Write the mode override register through the APB-style port only while
// the block is idle; the block does not enforce this. Reset is synchronous
// and resets all channel state, masks and override; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_status_byte,
   input  wire logic [7:0]                    req_first_data,
   input  wire logic [7:0]                    req_second_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_event_valid,
   output logic [2:0]                         rsp_event_kind,
   output logic [3:0]                         rsp_channel,
   output logic [6:0]                         rsp_first_value,
   output logic [6:0]                         rsp_second_value,
   output logic signed [20:0]                 rsp_bend_value,
   output logic [1:0]                         rsp_effective_mode,
   output logic [3:0]                         rsp_zone_member_count,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mmd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [mmd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mmd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import mmd_pkg::*;

   `include "midi_message_decoder_defines.svh"

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [7:0]         status_ff;
   logic [7:0]         first_ff;
   logic [7:0]         second_ff;
   logic [7:0]         prev_status_ff;
   logic [7:0]         prev_status_in;
   logic [1:0]         override_ff;
   logic [1:0]         override_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_free;
   logic               fire;
   logic               req_fire;
   logic               csr_sel_mode;
   msg_type            msg;
   zone_wr_type        zone_wr;
   logic [6:0]         bend_range;
   logic [1:0]         cur_mode;
   logic [3:0]         cur_members;
   logic [1:0]         next_mode;
   logic [3:0]         next_members;
   logic               ev_valid;
   event_kind_type     ev_kind;
   logic [3:0]         ev_ch;
   logic [6:0]         ev_first;
   logic [6:0]         ev_second;
   logic signed [13:0] bend_offset;
   logic signed [21:0] bend_product;
   logic signed [20:0] ev_bend;
   logic               ev_valid_ff;
   event_kind_type     ev_kind_ff;
   logic [3:0]         ev_ch_ff;
   logic [6:0]         ev_first_ff;
   logic [6:0]         ev_second_ff;
   logic signed [20:0] ev_bend_ff;
   logic [1:0]         mode_ff;
   logic [3:0]         members_ff;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   assign csr_sel_mode = (csr_paddr[CSR_ADDR_W-1:2] == CSR_MODE_OVERRIDE);
   assign override_in  = (csr_psel && csr_penable && csr_pwrite && csr_sel_mode)
                         ? csr_pwdata[1:0] : override_ff;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = csr_sel_mode ? {{(CSR_DATA_W-2){1'b0}}, override_ff} : '0;

   mmd_parse u_parse (
      .status_byte (status_ff),
      .first_data  (first_ff),
      .second_data (second_ff),
      .prev_status (prev_status_ff),
      .msg         (msg)
   );

   mmd_chan_regs u_chan_regs (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .msg         (msg),
      .cur_mode    (cur_mode),
      .cur_members (cur_members),
      .bend_range  (bend_range),
      .zone_wr     (zone_wr)
   );

   mmd_mode_track u_mode_track (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .msg           (msg),
      .zone_wr       (zone_wr),
      .mode_force    (override_ff),
      .cur_mode      (cur_mode),
      .cur_members   (cur_members),
      .next_mode     (next_mode),
      .next_members  (next_members)
   );

   assign prev_status_in = (fire && msg.ok) ? {msg.code, msg.ch} : prev_status_ff;

   assign bend_offset  = $signed({~msg.v2[6], msg.v2[5:0], msg.v1});
   assign bend_product = bend_offset * $signed({1'b0, bend_range});

   always_comb begin
      ev_valid  = 1'b0;
      ev_kind   = EV_NOTE_ON;
      ev_first  = '0;
      ev_second = '0;
      ev_bend   = '0;
      if (msg.ok) begin
         unique case (msg.code)
            ST_NOTE_ON: begin
               ev_valid  = 1'b1;
               ev_kind   = (msg.v2 == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
               ev_first  = msg.v1;
               ev_second = msg.v2;
            end
            ST_NOTE_OFF: begin
               ev_valid  = 1'b1;
               ev_kind   = EV_NOTE_OFF;
               ev_first  = msg.v1;
               ev_second = msg.v2;
            end
            ST_BEND: begin
               ev_valid = 1'b1;
               ev_kind  = EV_BEND;
               ev_bend  = bend_product[20:0];
            end
            ST_PRESSURE: begin
               ev_valid  = 1'b1;
               ev_kind   = EV_PRESSURE;
               ev_second = msg.v1;
            end
            ST_CONTROL: begin
               ev_valid  = 1'b1;
               ev_kind   = EV_CONTROL;
               ev_first  = msg.v1;
               ev_second = msg.v2;
            end
            default: begin
            end
         endcase
      end
      ev_ch = ev_valid ? msg.ch : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prev_status_ff <= '0;
         override_ff    <= MODE_AUTO;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         prev_status_ff <= prev_status_in;
         override_ff    <= override_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= req_status_byte;
         first_ff  <= req_first_data;
         second_ff <= req_second_data;
      end
      if (fire) begin
         ev_valid_ff  <= ev_valid;
         ev_kind_ff   <= ev_kind;
         ev_ch_ff     <= ev_ch;
         ev_first_ff  <= ev_first;
         ev_second_ff <= ev_second;
         ev_bend_ff   <= ev_bend;
         mode_ff      <= next_mode;
         members_ff   <= next_members;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_event_valid       = ev_valid_ff;
   assign rsp_event_kind        = ev_kind_ff;
   assign rsp_channel           = ev_ch_ff;
   assign rsp_first_value       = ev_first_ff;
   assign rsp_second_value      = ev_second_ff;
   assign rsp_bend_value        = ev_bend_ff;
   assign rsp_effective_mode    = mode_ff;
   assign rsp_zone_member_count = members_ff;

   `MMD_ASSERT_NEXT(a_decode_lands, fire, rsp_valid)
   `MMD_ASSERT_NEXT(a_request_held, req_fire, in_valid_ff)
   `MMD_ASSERT_SAME(a_no_event_clean, rsp_valid && !rsp_event_valid,
                    rsp_bend_value == 21'sd0 && rsp_first_value == 7'd0 && rsp_channel == 4'd0)
   `MMD_ASSERT_SAME(a_bend_only_on_bend, rsp_valid && rsp_event_kind != EV_BEND,
                    rsp_bend_value == 21'sd0)

endmodule

`default_nettype wire
